FILE: hw/rtl/led_rainbow_blink_sequencer_macros.svh
// Assertion macros shared by the sequencer RTL.
`ifndef LED_RAINBOW_BLINK_SEQUENCER_MACROS_SVH
`define LED_RAINBOW_BLINK_SEQUENCER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define LRB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define LRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LRB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define LRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/lrb_pkg.sv
// Types, constants and helper functions of the rainbow blink sequencer.
`timescale 1ns / 1ps
`default_nettype none
package lrb_pkg;

	// Register indexes on the configuration port (byte address is 4 times this).
	localparam logic [2:0] REG_BLINK_ON_TIME   = 3'd0;
	localparam logic [2:0] REG_BLINK_OFF_TIME  = 3'd1;
	localparam logic [2:0] REG_BLINK_REPEATS   = 3'd2;
	localparam logic [2:0] REG_HUE_STEP_PERIOD = 3'd3;
	localparam logic [2:0] REG_RAINBOW_LEVEL   = 3'd4;

	// Register reset values.
	localparam logic [15:0] RST_BLINK_ON_TIME   = 16'd200;
	localparam logic [15:0] RST_BLINK_OFF_TIME  = 16'd200;
	localparam logic [6:0]  RST_BLINK_REPEATS   = 7'd3;
	localparam logic [15:0] RST_HUE_STEP_PERIOD = 16'd50;
	localparam logic [6:0]  RST_RAINBOW_LEVEL   = 7'd20;

	// The hue is kept as a sector (0 to 5) and an offset within it (0 to 59).
	localparam logic [5:0] HUE_OFFSET_LAST = 6'd59;
	localparam logic [2:0] HUE_SECTOR_LAST = 3'd5;

	// Reciprocals: floor(x/100) = (x*5243)>>19 for x below 32768,
	// floor(x/60) = (x*17477)>>20 for x below 16384.
	localparam logic [12:0] DIV100_MUL = 13'd5243;
	localparam logic [14:0] DIV60_MUL  = 15'd17477;

	localparam logic [7:0] CHANNEL_FULL = 8'hFF;
	localparam logic [7:0] CHANNEL_DARK = 8'h00;

	// One colour request on its way from the decision stage to the output register.
	typedef struct packed {
		logic       blink;
		logic       blue_on;
		logic [2:0] sector;
		logic [13:0] prod;
		logic [7:0] maxc;
	} lrb_s2_t;

	// Brightness percent to peak channel value: min(255, floor(level*255/100)).
	function automatic logic [7:0] level_to_maxc(input logic [6:0] level);
		logic [14:0] scaled;
		logic [27:0] prod;
		logic [8:0]  quot;
		scaled = {level, 8'b0} - 15'(level);
		prod   = 28'(scaled) * 28'(DIV100_MUL);
		quot   = prod[27:19];
		return (quot > 9'd255) ? CHANNEL_FULL : quot[7:0];
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/lrb_if.sv
// Valid/ready channel interfaces for the poll and colour requests.
`timescale 1ns / 1ps
`default_nettype none
interface lrb_poll_if;
	logic        valid;
	logic        ready;
	logic [31:0] time_now;
	logic        blink_request;

	modport source (output valid, output time_now, output blink_request, input ready);
	modport sink (input valid, input time_now, input blink_request, output ready);
endinterface

interface lrb_color_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/led_rainbow_blink_sequencer.sv
// Rainbow LED sequencer with a blue blink overlay: top level.
// Usage: the poll channel carries one request per poll with the current
// millisecond time and a blink request bit. Each poll yields zero or one
// colour request on the color channel (red, green, blue). A blink request is
// latched and starts a blue/dark blink of max(1, 2*blink_repeats) phases as soon as
// no blink runs; otherwise the hue steps every hue_step_period ms and a
// full-saturation colour at rainbow_level percent is sent.
// Path: a colour request is registered in the input register, then in the output
// register, before it is valid on color.
// Throughput: one poll per cycle while color is taken. The rate is set by the
// sequencer state update between the two registers, which every poll passes once.
// Stalls: when the receiver holds color.ready low, the output register holds
// its request and the input register fills; poll.ready drops only when both
// are full.
// Reset: arst_n low clears both registers, the sequencer state and the
// configuration registers to their documented defaults. No clearing pass.
// Configuration is an APB-style port; register i lies at byte address 4*i,
// writes are applied at the access cycle and reads return the register value.
`timescale 1ns / 1ps
`default_nettype none
`include "led_rainbow_blink_sequencer_macros.svh"
module led_rainbow_blink_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lrb_poll_if.sink         poll,
	lrb_color_if.source      color,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [15:0] blink_on_time_q;
	logic [15:0] blink_off_time_q;
	logic [6:0]  blink_repeats_q;
	logic [15:0] hue_step_period_q;
	logic [6:0]  rainbow_level_q;
	// Peak channel value, derived from rainbow_level_q whenever it is written so
	// that the per-poll path carries only one multiplication of two variables.
	logic [7:0]  maxc_q;
	logic        cfg_write;
	logic [2:0]  cfg_idx;

	assign pready    = 1'b1;
	assign cfg_idx   = paddr[4:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_on_time_q   <= lrb_pkg::RST_BLINK_ON_TIME;
			blink_off_time_q  <= lrb_pkg::RST_BLINK_OFF_TIME;
			blink_repeats_q   <= lrb_pkg::RST_BLINK_REPEATS;
			hue_step_period_q <= lrb_pkg::RST_HUE_STEP_PERIOD;
			rainbow_level_q   <= lrb_pkg::RST_RAINBOW_LEVEL;
			maxc_q            <= lrb_pkg::level_to_maxc(lrb_pkg::RST_RAINBOW_LEVEL);
		end else if (cfg_write) begin
			case (cfg_idx)
				lrb_pkg::REG_BLINK_ON_TIME: begin
					blink_on_time_q <= pwdata[15:0];
				end
				lrb_pkg::REG_BLINK_OFF_TIME: begin
					blink_off_time_q <= pwdata[15:0];
				end
				lrb_pkg::REG_BLINK_REPEATS: begin
					blink_repeats_q <= pwdata[6:0];
				end
				lrb_pkg::REG_HUE_STEP_PERIOD: begin
					hue_step_period_q <= pwdata[15:0];
				end
				lrb_pkg::REG_RAINBOW_LEVEL: begin
					rainbow_level_q <= pwdata[6:0];
					maxc_q          <= lrb_pkg::level_to_maxc(pwdata[6:0]);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			lrb_pkg::REG_BLINK_ON_TIME:   prdata = 32'(blink_on_time_q);
			lrb_pkg::REG_BLINK_OFF_TIME:  prdata = 32'(blink_off_time_q);
			lrb_pkg::REG_BLINK_REPEATS:   prdata = 32'(blink_repeats_q);
			lrb_pkg::REG_HUE_STEP_PERIOD: prdata = 32'(hue_step_period_q);
			lrb_pkg::REG_RAINBOW_LEVEL:   prdata = 32'(rainbow_level_q);
			default:                      prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Flow control. The input register moves on when the output register is
	// empty or being taken.
	// ------------------------------------------------------------------
	logic        s1_valid_q;
	logic [31:0] time_s1;
	logic        req_s1;
	logic        out_valid_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;

	logic out_move;
	logic s1_fire;

	assign out_move   = !out_valid_q || color.ready;
	assign s1_fire    = s1_valid_q && out_move;
	assign poll.ready = !s1_valid_q || out_move;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (poll.ready) begin
			s1_valid_q <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			time_s1 <= poll.time_now;
			req_s1  <= poll.blink_request;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer state and the decision logic
	// ------------------------------------------------------------------
	logic        pending_q;
	logic        running_q;
	logic [7:0]  count_q;
	logic [31:0] deadline_q;
	logic        deadline_valid_q;
	logic [31:0] last_hue_time_q;
	logic [2:0]  sector_q;
	logic [5:0]  offset_q;

	logic        pending_d;
	logic        running_d;
	logic [7:0]  count_d;
	logic [31:0] deadline_d;
	logic        deadline_valid_d;
	logic [31:0] last_hue_time_d;
	logic [2:0]  sector_d;
	logic [5:0]  offset_d;
	logic        res_valid;
	lrb_pkg::lrb_s2_t res;

	logic        pend;
	logic        start;
	logic        dv;
	logic [7:0]  cnt;
	logic [31:0] dl_diff;
	logic [31:0] hue_diff;
	logic [7:0]  cnt_next;

	always_comb begin
		pend     = pending_q || req_s1;
		start    = !running_q && pend;
		dv       = start ? 1'b0 : deadline_valid_q;
		cnt      = start ? 8'd0 : count_q;
		cnt_next = cnt + 8'd1;
		dl_diff  = time_s1 - deadline_q;
		hue_diff = time_s1 - last_hue_time_q;

		pending_d        = start ? 1'b0 : pend;
		running_d        = running_q || start;
		count_d          = cnt;
		deadline_d       = deadline_q;
		deadline_valid_d = dv;
		last_hue_time_d  = last_hue_time_q;
		sector_d         = sector_q;
		offset_d         = offset_q;

		res_valid   = 1'b0;
		res.blink   = 1'b0;
		res.blue_on = 1'b0;
		res.sector  = sector_q;
		res.prod    = 14'(maxc_q) * 14'(offset_q);
		res.maxc    = maxc_q;

		if (running_q || start) begin
			// A phase ends when no deadline is set yet or the deadline is reached.
			if (!dv || !dl_diff[31]) begin
				res_valid   = 1'b1;
				res.blink   = 1'b1;
				res.blue_on = !cnt[0];
				deadline_d  = time_s1 + 32'(cnt[0] ? blink_off_time_q : blink_on_time_q);
				count_d     = cnt_next;
				if (cnt_next >= {blink_repeats_q, 1'b0}) begin
					running_d        = 1'b0;
					deadline_valid_d = 1'b0;
				end else begin
					deadline_valid_d = 1'b1;
				end
			end
		end else if (!hue_diff[31] && (hue_diff >= 32'(hue_step_period_q))) begin
			res_valid       = 1'b1;
			last_hue_time_d = time_s1;
			if (offset_q == lrb_pkg::HUE_OFFSET_LAST) begin
				offset_d = 6'd0;
				sector_d = (sector_q == lrb_pkg::HUE_SECTOR_LAST) ? 3'd0 : sector_q + 3'd1;
			end else begin
				offset_d = offset_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q        <= 1'b0;
			running_q        <= 1'b0;
			count_q          <= 8'd0;
			deadline_q       <= 32'd0;
			deadline_valid_q <= 1'b0;
			last_hue_time_q  <= 32'd0;
			sector_q         <= 3'd0;
			offset_q         <= 6'd0;
		end else if (s1_fire) begin
			pending_q        <= pending_d;
			running_q        <= running_d;
			count_q          <= count_d;
			deadline_q       <= deadline_d;
			deadline_valid_q <= deadline_valid_d;
			last_hue_time_q  <= last_hue_time_d;
			sector_q         <= sector_d;
			offset_q         <= offset_d;
		end
	end

	// ------------------------------------------------------------------
	// Colour logic: finishes the hue ramp division and picks the channels.
	// The ramp product depends only on registered state, so it runs in
	// parallel with the decision above.
	// ------------------------------------------------------------------
	logic [27:0] adj_prod;
	logic [7:0]  adj;
	logic [7:0]  red_d;
	logic [7:0]  green_d;
	logic [7:0]  blue_d;

	always_comb begin
		adj_prod = 28'(res.prod) * 28'(lrb_pkg::DIV60_MUL);
		adj      = adj_prod[27:20];
		if (res.blink) begin
			red_d   = lrb_pkg::CHANNEL_DARK;
			green_d = lrb_pkg::CHANNEL_DARK;
			blue_d  = res.blue_on ? lrb_pkg::CHANNEL_FULL : lrb_pkg::CHANNEL_DARK;
		end else begin
			case (res.sector)
				3'd0: begin
					red_d = res.maxc; green_d = adj; blue_d = lrb_pkg::CHANNEL_DARK;
				end
				3'd1: begin
					red_d = res.maxc - adj; green_d = res.maxc;
					blue_d = lrb_pkg::CHANNEL_DARK;
				end
				3'd2: begin
					red_d = lrb_pkg::CHANNEL_DARK; green_d = res.maxc; blue_d = adj;
				end
				3'd3: begin
					red_d = lrb_pkg::CHANNEL_DARK; green_d = res.maxc - adj;
					blue_d = res.maxc;
				end
				3'd4: begin
					red_d = adj; green_d = lrb_pkg::CHANNEL_DARK; blue_d = res.maxc;
				end
				default: begin
					red_d = res.maxc; green_d = lrb_pkg::CHANNEL_DARK;
					blue_d = res.maxc - adj;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_move) begin
			out_valid_q <= s1_fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res_valid) begin
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
		end
	end

	assign color.valid = out_valid_q;
	assign color.red   = red_q;
	assign color.green = green_q;
	assign color.blue  = blue_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`LRB_ASSERT_IMPL(a_deadline_only_in_blink, clk, arst_n, deadline_valid_q, running_q,
		"phase deadline armed while no blink runs")
	`LRB_ASSERT_IMPL(a_hue_in_range, clk, arst_n, 1'b1,
		(offset_q <= lrb_pkg::HUE_OFFSET_LAST) && (sector_q <= lrb_pkg::HUE_SECTOR_LAST),
		"hue sector or offset out of range")
	`LRB_ASSERT_IMPL(a_stall_needs_full_input, clk, arst_n, !poll.ready,
		s1_valid_q && out_valid_q, "poll stalled with room in the pipeline")
	`LRB_ASSERT_NEXT(a_result_reaches_output, clk, arst_n, s1_fire && res_valid, out_valid_q,
		"decided colour request lost before the output register")

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the rainbow blink sequencer top level.
`timescale 1ns / 1ps
module tb;

	// One colour request as the color channel carries it.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// How the two channels are paced during a phase of the run.
	typedef enum logic [1:0] {PACE_FREE, PACE_SRC_GAPS, PACE_SINK_STALLS, PACE_BOTH} pace_t;

	typedef enum logic {ROW_POLL, ROW_WRITE} row_kind_t;

	// One line of the directed table. For a poll, data is time_now; for a register
	// write, data is the value written to register idx. When typed is set, the
	// expected outcome (some, color) is taken from the row instead of the predictor.
	typedef struct {
		row_kind_t   kind;
		logic [31:0] data;
		logic        req;
		logic [2:0]  idx;
		logic        typed;
		logic        some;
		rgb_t        color;
	} stim_row_t;

	// Register index past the end of the map; writes there must change nothing.
	localparam logic [2:0] REG_UNUSED = 3'd5;

	localparam rgb_t COLOR_BLUE  = {lrb_pkg::CHANNEL_DARK, lrb_pkg::CHANNEL_DARK,
		lrb_pkg::CHANNEL_FULL};
	localparam rgb_t COLOR_BLACK = {lrb_pkg::CHANNEL_DARK, lrb_pkg::CHANNEL_DARK,
		lrb_pkg::CHANNEL_DARK};

	localparam int HUE_SPAN      = 360;
	localparam int SECTOR_SPAN   = 60;
	localparam int LATENCY_SLACK = 8;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 250;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lrb_poll_if  poll_ch();
	lrb_color_if color_ch();

	led_rainbow_blink_sequencer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.poll    (poll_ch),
		.color   (color_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Colours the block still owes us, oldest first.
	rgb_t  color_due[$];
	int    mismatch_count = 0;
	pace_t pace = PACE_FREE;

	// Shadow copy of the configuration registers.
	logic [15:0] on_ms      = lrb_pkg::RST_BLINK_ON_TIME;
	logic [15:0] off_ms     = lrb_pkg::RST_BLINK_OFF_TIME;
	logic [6:0]  pairs      = lrb_pkg::RST_BLINK_REPEATS;
	logic [15:0] hue_period = lrb_pkg::RST_HUE_STEP_PERIOD;
	logic [6:0]  level_pct  = lrb_pkg::RST_RAINBOW_LEVEL;

	// Shadow copy of the sequencer state.
	logic        req_latched = 1'b0;
	logic        blinking    = 1'b0;
	logic [7:0]  phases_done = 8'd0;
	logic [31:0] phase_end   = 32'd0;
	logic        end_armed   = 1'b0;
	logic [31:0] hue_time    = 32'd0;
	logic [8:0]  hue         = 9'd0;

	// The clock runs free from time zero with a 12 ns period.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Safety net: a hung handshake ends the run here.
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// Full-saturation colour for a hue angle at a brightness in percent. The peak
	// channel is the integer form of level*2.55, clipped to 255 for levels above 100.
	function automatic rgb_t hue_color(input logic [8:0] h, input logic [6:0] lvl);
		int peak, adj, r, g, b;
		peak = (int'(lvl) * 255) / 100;
		if (peak > 255)
			peak = 255;
		adj = (peak * (int'(h) % SECTOR_SPAN)) / SECTOR_SPAN;
		case (int'(h) / SECTOR_SPAN)
			0: begin r = peak;       g = adj;        b = 0;          end
			1: begin r = peak - adj; g = peak;       b = 0;          end
			2: begin r = 0;          g = peak;       b = adj;        end
			3: begin r = 0;          g = peak - adj; b = peak;       end
			4: begin r = adj;        g = 0;          b = peak;       end
			default: begin r = peak; g = 0;          b = peak - adj; end
		endcase
		return {8'(r), 8'(g), 8'(b)};
	endfunction

	// Advances the shadow sequencer by one accepted poll. Returns 1 when the
	// poll produces a colour, which is then left in c.
	function automatic logic predict_color(input logic [31:0] now, input logic req,
		output rgb_t c);
		logic [31:0] since;
		c = '0;
		if (req)
			req_latched = 1'b1;
		// A latched request starts a blink as soon as none is running, and the
		// fresh blink has no deadline, so its first phase shows in this poll.
		if (!blinking && req_latched) begin
			req_latched = 1'b0;
			blinking    = 1'b1;
			phases_done = 8'd0;
			end_armed   = 1'b0;
			phase_end   = 32'd0;
		end
		if (blinking) begin
			// Times compare modulo 2^32: the deadline is reached when the
			// distance to it has its sign bit clear.
			since = now - phase_end;
			if (end_armed && since[31])
				return 1'b0;
			c.red   = lrb_pkg::CHANNEL_DARK;
			c.green = lrb_pkg::CHANNEL_DARK;
			if (phases_done[0]) begin
				c.blue    = lrb_pkg::CHANNEL_DARK;
				phase_end = now + off_ms;
			end else begin
				c.blue    = lrb_pkg::CHANNEL_FULL;
				phase_end = now + on_ms;
			end
			end_armed   = 1'b1;
			phases_done = phases_done + 8'd1;
			// With zero pairs configured, this ends the blink after its blue phase.
			if (phases_done >= {pairs, 1'b0}) begin
				blinking  = 1'b0;
				end_armed = 1'b0;
				phase_end = 32'd0;
			end
			return 1'b1;
		end
		since = now - hue_time;
		if (since[31] || since < hue_period)
			return 1'b0;
		hue_time = now;
		c        = hue_color(hue, level_pct);
		hue      = (hue == 9'(HUE_SPAN - 1)) ? 9'd0 : hue + 9'd1;
		return 1'b1;
	endfunction

	// One APB transfer: setup cycle, then access cycle until pready. Read data
	// is sampled at the rising edge that completes the access.
	task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = {idx, 2'b00};
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Writes a register, mirrors the write in the shadow copy (masked to the
	// register width) and reads it back. The unused index is written only.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] back, want;
		logic        known;
		apb_access(1'b1, idx, value, back);
		known = 1'b1;
		case (idx)
			lrb_pkg::REG_BLINK_ON_TIME: begin
				on_ms = value[15:0];
				want  = {16'd0, value[15:0]};
			end
			lrb_pkg::REG_BLINK_OFF_TIME: begin
				off_ms = value[15:0];
				want   = {16'd0, value[15:0]};
			end
			lrb_pkg::REG_BLINK_REPEATS: begin
				pairs = value[6:0];
				want  = {25'd0, value[6:0]};
			end
			lrb_pkg::REG_HUE_STEP_PERIOD: begin
				hue_period = value[15:0];
				want       = {16'd0, value[15:0]};
			end
			lrb_pkg::REG_RAINBOW_LEVEL: begin
				level_pct = value[6:0];
				want      = {25'd0, value[6:0]};
			end
			default: begin
				known = 1'b0;
				want  = 32'd0;
			end
		endcase
		if (known) begin
			apb_access(1'b0, idx, 32'd0, back);
			if (back !== want)
				flag_mismatch($sformatf("register %0d reads %0h, expected %0h", idx, back,
					want));
		end
	endtask

	// Offers one poll, with random gaps before it in the gapped pacing modes,
	// and runs the predictor once the request is taken.
	task automatic send_poll(input logic [31:0] now, input logic req, output logic some,
		output rgb_t c);
		@(negedge clk);
		while ((pace == PACE_SRC_GAPS && $urandom_range(0, 99) < 70) ||
			(pace == PACE_BOTH && $urandom_range(0, 99) < 23)) begin
			poll_ch.valid = 1'b0;
			@(negedge clk);
		end
		poll_ch.valid         = 1'b1;
		poll_ch.time_now      = now;
		poll_ch.blink_request = req;
		do @(posedge clk); while (!poll_ch.ready);
		some = predict_color(now, req, c);
	endtask

	// Stops offering polls and waits until every owed colour has come. Polls
	// that produce nothing may still be in the pipe, so the task keeps waiting
	// for them to drain before the caller touches the registers.
	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		poll_ch.valid = 1'b0;
		while (color_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (color_due.size() != 0) begin
			flag_mismatch($sformatf("%0d colour requests never arrived", color_due.size()));
			color_due.delete();
		end
		repeat (LATENCY_SLACK) @(posedge clk);
	endtask

	function automatic stim_row_t poll_row(input logic [31:0] t, input logic req);
		stim_row_t r;
		r.kind  = ROW_POLL;
		r.data  = t;
		r.req   = req;
		r.typed = 1'b0;
		r.some  = 1'b0;
		r.color = '0;
		return r;
	endfunction

	function automatic stim_row_t typed_row(input logic [31:0] t, input logic req,
		input logic some, input rgb_t col);
		stim_row_t r;
		r       = poll_row(t, req);
		r.typed = 1'b1;
		r.some  = some;
		r.color = col;
		return r;
	endfunction

	function automatic stim_row_t write_row(input logic [2:0] idx, input logic [31:0] value);
		stim_row_t r;
		r      = poll_row(32'd0, 1'b0);
		r.kind = ROW_WRITE;
		r.idx  = idx;
		r.data = value;
		return r;
	endfunction

	// The receiver side: ready is redrawn at every falling edge according to the
	// current pacing mode.
	always @(negedge clk) begin
		color_ch.ready = !((pace == PACE_SINK_STALLS && $urandom_range(0, 99) < 70) ||
			(pace == PACE_BOTH && $urandom_range(0, 99) < 23));
	end

	// Every colour request taken from the block must match the oldest one owed.
	always @(posedge clk) begin : check_color
		rgb_t want;
		if (arst_n && color_ch.valid && color_ch.ready) begin
			if (color_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected colour %0d/%0d/%0d", color_ch.red,
					color_ch.green, color_ch.blue));
			end else begin
				want = color_due.pop_front();
				if (color_ch.red !== want.red)
					flag_mismatch($sformatf("red %0d, expected %0d", color_ch.red, want.red));
				if (color_ch.green !== want.green)
					flag_mismatch($sformatf("green %0d, expected %0d", color_ch.green,
						want.green));
				if (color_ch.blue !== want.blue)
					flag_mismatch($sformatf("blue %0d, expected %0d", color_ch.blue,
						want.blue));
			end
		end
	end

	initial begin
		stim_row_t   rows[$];
		stim_row_t   row;
		rgb_t        c;
		logic        some;
		logic [31:0] now, span, junk;
		logic [15:0] v_on, v_off, v_period;
		logic [6:0]  v_pairs, v_level;
		int          req_pct, pick;

		// All block inputs are known from time zero.
		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		poll_ch.valid         = 1'b0;
		poll_ch.time_now      = '0;
		poll_ch.blink_request = 1'b0;
		color_ch.ready        = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, starting from the reset configuration, where the rainbow
		// peak channel is 51. First a hue step exactly one period after reset,
		// then a blink with a request arriving mid-blink that must start a second
		// blink in the poll right after the first one ends.
		rows.push_back(typed_row(32'd0, 1'b0, 1'b0, '0));
		rows.push_back(typed_row(32'd50, 1'b0, 1'b1, {8'd51, 8'd0, 8'd0}));
		rows.push_back(poll_row(32'd100, 1'b0));
		rows.push_back(typed_row(32'd100, 1'b1, 1'b1, COLOR_BLUE));
		rows.push_back(typed_row(32'd299, 1'b0, 1'b0, '0));
		rows.push_back(typed_row(32'd300, 1'b0, 1'b1, COLOR_BLACK));
		rows.push_back(typed_row(32'd500, 1'b1, 1'b1, COLOR_BLUE));
		rows.push_back(poll_row(32'd700, 1'b0));
		rows.push_back(poll_row(32'd900, 1'b0));
		rows.push_back(poll_row(32'd1100, 1'b0));
		rows.push_back(typed_row(32'd1100, 1'b0, 1'b1, COLOR_BLUE));
		// Deadlines seen from far away and from just before, across the wrap.
		rows.push_back(poll_row(32'hFFFF_FF00, 1'b0));
		rows.push_back(poll_row(32'h8000_0514, 1'b0));
		rows.push_back(poll_row(32'h0000_0513, 1'b0));
		rows.push_back(poll_row(32'd1300, 1'b0));
		// Extreme settings: brightness above 100, a zero hue period, zero pairs, a zero
		// on time, the largest off time and a write to an index past the register map.
		rows.push_back(write_row(lrb_pkg::REG_RAINBOW_LEVEL, 32'd127));
		rows.push_back(write_row(lrb_pkg::REG_HUE_STEP_PERIOD, 32'd0));
		rows.push_back(write_row(lrb_pkg::REG_BLINK_REPEATS, 32'd0));
		rows.push_back(write_row(lrb_pkg::REG_BLINK_ON_TIME, 32'd0));
		rows.push_back(write_row(lrb_pkg::REG_BLINK_OFF_TIME, 32'hFFFF));
		rows.push_back(write_row(REG_UNUSED, 32'hFFFF_FFFF));
		rows.push_back(poll_row(32'd1300, 1'b0));
		rows.push_back(poll_row(32'd1500, 1'b0));
		rows.push_back(typed_row(32'd1500, 1'b0, 1'b1, {8'd255, 8'd8, 8'd0}));
		rows.push_back(typed_row(32'd1500, 1'b1, 1'b1, COLOR_BLUE));
		rows.push_back(poll_row(32'd1500, 1'b0));
		rows.push_back(typed_row(32'hFFFF_FFFF, 1'b1, 1'b1, COLOR_BLUE));
		rows.push_back(poll_row(32'h0000_0000, 1'b0));
		rows.push_back(poll_row(32'h8000_05DC, 1'b0));
		rows.push_back(poll_row(32'h7FFF_FFFF, 1'b0));
		rows.push_back(poll_row(32'h8000_0000, 1'b0));

		foreach (rows[i]) begin
			row = rows[i];
			if (row.kind == ROW_WRITE) begin
				settle();
				write_reg(row.idx, row.data);
			end else begin
				send_poll(row.data, row.req, some, c);
				if (row.typed) begin
					if (row.some)
						color_due.push_back(row.color);
				end else if (some) begin
					color_due.push_back(c);
				end
			end
		end
		now = 32'h8000_0000;

		// Random part. Each phase programs every register while the block is
		// idle and then uses one pacing mode; the first three phases pin the
		// settings to their extremes. Later phases also put junk in the unused
		// upper bits of each write, which the registers must drop.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					v_on = 16'd0; v_off = 16'd0; v_pairs = 7'd1; v_period = 16'd0;
					v_level = 7'd0;
				end
				1: begin
					v_on = 16'hFFFF; v_off = 16'd0; v_pairs = 7'd2; v_period = 16'hFFFF;
					v_level = 7'd100;
				end
				2: begin
					v_on = 16'd3; v_off = 16'd1; v_pairs = 7'd127; v_period = 16'd1;
					v_level = 7'd127;
				end
				default: begin
					v_on     = ($urandom_range(0, 7) == 0) ? 16'($urandom()) :
						16'($urandom_range(0, 400));
					v_off    = ($urandom_range(0, 7) == 0) ? 16'($urandom()) :
						16'($urandom_range(0, 400));
					v_pairs  = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) :
						7'($urandom_range(0, 9));
					v_period = 16'($urandom_range(0, 60));
					v_level  = 7'($urandom_range(0, 127));
				end
			endcase
			junk = (ph >= 3) ? $urandom() : 32'd0;
			settle();
			write_reg(lrb_pkg::REG_BLINK_ON_TIME, {junk[31:16], v_on});
			write_reg(lrb_pkg::REG_BLINK_OFF_TIME, {junk[31:16], v_off});
			write_reg(lrb_pkg::REG_BLINK_REPEATS, {junk[31:7], v_pairs});
			write_reg(lrb_pkg::REG_HUE_STEP_PERIOD, {junk[31:16], v_period});
			write_reg(lrb_pkg::REG_RAINBOW_LEVEL, {junk[31:7], v_level});
			pace    = pace_t'(ph % 4);
			req_pct = $urandom_range(1, 10);

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Halfway through each phase, and now and then at random, the
				// sender holds off until the block has delivered everything.
				if (n == PHASE_ITEMS / 2 || $urandom_range(0, 99) == 0)
					settle();
				// Time mostly moves forward in steps scaled to the longest
				// configured duration, so blinks and hue steps both make
				// progress; a few polls jump anywhere, go back, or repeat.
				span = on_ms;
				if (off_ms > span)
					span = off_ms;
				if (hue_period > span)
					span = hue_period;
				pick = $urandom_range(0, 199);
				if (pick < 3)
					now = $urandom();
				else if (pick < 10)
					now = now - $urandom_range(1, span + 1);
				else if (pick >= 16)
					now = now + $urandom_range(0, span / 2 + 3);
				send_poll(now, $urandom_range(0, 99) < req_pct, some, c);
				if (some)
					color_due.push_back(c);
			end
		end

		settle();
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: led_rainbow_blink_sequencer.f
+incdir+hw/rtl
hw/rtl/lrb_pkg.sv
hw/rtl/lrb_if.sv
hw/rtl/led_rainbow_blink_sequencer.sv
dv/tb.sv
